// ===== src/spq_pkg.sv =====
// Shared types and constants for the stable priority queue.
// No dependencies; every other file imports this package.
`default_nettype none

package spq_pkg;

    localparam int DATA_W  = 32;
    localparam int PRIO_W  = 8;
    localparam int OPRIO_W = 9;
    localparam int OCC_W   = 5;
    localparam int STAT_W  = 2;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_POP,
        OP_REJECT_FULL,
        OP_REJECT_EMPTY
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } stat_t;

endpackage

`default_nettype wire

// ===== src/spq_if.sv =====
// Request and response channel interfaces of the stable priority queue.
// Depends on spq_pkg for field widths.
`default_nettype none

interface spq_req_if
    import spq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic signed [DATA_W-1:0] in_data;
    logic [PRIO_W-1:0]        in_prio;

    modport source (output valid, output func, output in_data, output in_prio, input ready);
    modport sink   (input valid, input func, input in_data, input in_prio, output ready);
endinterface

interface spq_rsp_if
    import spq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [STAT_W-1:0]         status;
    logic signed [DATA_W-1:0]  out_data;
    logic signed [OPRIO_W-1:0] out_prio;
    logic [OCC_W-1:0]          occupancy;

    modport source (output valid, output status, output out_data, output out_prio,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_data, input out_prio,
                    input occupancy, output ready);
endinterface

`default_nettype wire

// ===== src/stable_priority_queue_unit.sv =====
// Stable priority queue: sorted shift-register cells, lower priority first, FIFO on ties.
// Latency: a result is valid the cycle after its request transaction is accepted.
// Throughput: one transaction per cycle while the receiver takes each result; every cell
// compares and shifts in parallel, so an insert or a removal updates all cells at once.
// Reset: asynchronous, empties the queue and drops any held result.
// Depends on spq_pkg, spq_if, spq_ctrl and spq_datapath.
`default_nettype none

module stable_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp
);

    cmd_t  cmd;
    stat_t stat;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .func      (req.func),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (req.in_data),
        .in_prio   (req.in_prio),
        .stat      (stat),
        .status    (rsp.status),
        .out_data  (rsp.out_data),
        .out_prio  (rsp.out_prio),
        .occupancy (rsp.occupancy)
    );

endmodule

`default_nettype wire

// ===== src/spq_datapath.sv =====
// Sorted shift-register cells, entry count and result register.
// Depends on spq_pkg; driven by spq_ctrl through cmd_t.
`default_nettype none

module spq_datapath
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cmd_t                      cmd,
    input  wire logic signed [DATA_W-1:0]  in_data,
    input  wire logic [PRIO_W-1:0]         in_prio,
    output stat_t                          stat,
    output logic [STAT_W-1:0]              status,
    output logic signed [DATA_W-1:0]       out_data,
    output logic signed [OPRIO_W-1:0]      out_prio,
    output logic [OCC_W-1:0]               occupancy
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] data_reg [QUEUE_DEPTH];
    logic [PRIO_W-1:0] prio_reg [QUEUE_DEPTH];
    logic [DATA_W-1:0] data_next [QUEUE_DEPTH];
    logic [PRIO_W-1:0] prio_next [QUEUE_DEPTH];
    logic [DATA_W-1:0] up_data [QUEUE_DEPTH];
    logic [PRIO_W-1:0] up_prio [QUEUE_DEPTH];
    logic [DATA_W-1:0] dn_data [QUEUE_DEPTH];
    logic [PRIO_W-1:0] dn_prio [QUEUE_DEPTH];

    logic [QUEUE_DEPTH-1:0] le;
    logic [QUEUE_DEPTH-1:0] le_prev;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CNT_W+OCC_W-1:0] count_ext;

    logic [STAT_W-1:0]         status_reg, status_next;
    logic signed [DATA_W-1:0]  odata_reg, odata_next;
    logic signed [OPRIO_W-1:0] oprio_reg, oprio_next;
    logic [OCC_W-1:0]          occ_reg, occ_next;

    // Each occupied cell compares against the incoming priority in parallel;
    // the hits form a thermometer code that marks the insertion point.
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            le[i] = (CNT_W'(i) < count_reg) && (prio_reg[i] <= in_prio);
        end
        le_prev = {le[QUEUE_DEPTH-2:0], 1'b1};
    end

    always_comb
    begin
        up_data[0] = in_data;
        up_prio[0] = in_prio;
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
            up_data[i] = data_reg[i-1];
            up_prio[i] = prio_reg[i-1];
        end
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            dn_data[i] = data_reg[i+1];
            dn_prio[i] = prio_reg[i+1];
        end
        dn_data[QUEUE_DEPTH-1] = data_reg[QUEUE_DEPTH-1];
        dn_prio[QUEUE_DEPTH-1] = prio_reg[QUEUE_DEPTH-1];
    end

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            data_next[i] = data_reg[i];
            prio_next[i] = prio_reg[i];
            case (cmd.op)
                OP_PUSH:
                begin
                    if (!le[i]) begin
                        // insert at the boundary, shift everything behind it up
                        data_next[i] = le_prev[i] ? in_data : up_data[i];
                        prio_next[i] = le_prev[i] ? in_prio : up_prio[i];
                    end
                end
                OP_POP:
                begin
                    data_next[i] = dn_data[i];
                    prio_next[i] = dn_prio[i];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        odata_next  = odata_reg;
        oprio_next  = oprio_reg;
        case (cmd.op)
            OP_PUSH:
            begin
                count_next  = count_reg + CNT_W'(1);
                status_next = STATUS_OK;
                odata_next  = '0;
                oprio_next  = '0;
            end
            OP_POP:
            begin
                count_next  = count_reg - CNT_W'(1);
                status_next = STATUS_OK;
                odata_next  = data_reg[0];
                oprio_next  = {1'b0, prio_reg[0]};
            end
            OP_REJECT_FULL:
            begin
                status_next = STATUS_FULL;
                odata_next  = '0;
                oprio_next  = '0;
            end
            OP_REJECT_EMPTY:
            begin
                status_next = STATUS_EMPTY;
                odata_next  = '1;
                oprio_next  = '1;
            end
            default:
            begin
            end
        endcase
        count_ext = (CNT_W + OCC_W)'(count_next);
        occ_next  = (cmd.op == OP_NONE) ? occ_reg : count_ext[OCC_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            data_reg[i] <= data_next[i];
            prio_reg[i] <= prio_next[i];
        end
        status_reg <= status_next;
        odata_reg  <= odata_next;
        oprio_reg  <= oprio_next;
        occ_reg    <= occ_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign status     = status_reg;
    assign out_data   = odata_reg;
    assign out_prio   = oprio_reg;
    assign occupancy  = occ_reg;

endmodule

`default_nettype wire

// ===== src/spq_ctrl.sv =====
// Controller: request/response handshake and operation select.
// Depends on spq_pkg; commands spq_datapath through cmd_t.
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire logic  func,
    output logic       out_valid,
    input  wire logic  out_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic {
        S_OPEN,
        S_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   exec;

    // A held result may leave in the same cycle a new transaction arrives.
    assign in_ready  = (state_reg == S_OPEN) || out_ready;
    assign exec      = in_valid && in_ready;
    assign out_valid = (state_reg == S_HOLD);

    always_comb
    begin
        cmd.op = OP_NONE;
        if (exec) begin
            if (func == FUNC_ENQ) begin
                cmd.op = stat.full ? OP_REJECT_FULL : OP_PUSH;
            end else begin
                cmd.op = stat.empty ? OP_REJECT_EMPTY : OP_POP;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_OPEN:
            begin
                if (exec) begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (!exec && out_ready) begin
                    state_next = S_OPEN;
                end
            end
            default:
            begin
                state_next = S_OPEN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_OPEN;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== sim/stable_priority_queue_unit_tb.sv =====
// Self-checking bench for stable_priority_queue_unit: predicts every response of the
// sorted queue (priority order, FIFO on ties, full and empty rejects) and compares it.
// Depends on spq_pkg, spq_if and the RTL of the queue.

module stable_priority_queue_unit_tb;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_ITEMS  = 380;

    typedef struct {
        logic [STAT_W-1:0]         status;
        logic signed [DATA_W-1:0]  data;
        logic signed [OPRIO_W-1:0] prio;
        logic [OCC_W-1:0]          occupancy;
    } queue_result_t;

    logic clk;
    logic rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    stable_priority_queue_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // predictor state: sorted entries, front at index 0
    logic signed [DATA_W-1:0] sorted_value [QUEUE_DEPTH];
    logic [PRIO_W-1:0]        sorted_prio  [QUEUE_DEPTH];
    int                       sorted_count;

    queue_result_t expected_results [$];
    queue_result_t want;

    int send_idle_pct;
    int rsp_stall_pct;
    int hold_left;
    int idle_cycles;
    int mismatches;
    int results_checked;
    int pops_ok;
    int rejects_full;
    int rejects_empty;

    always #5 clk = ~clk;

    function automatic queue_result_t sorted_queue_apply(input logic func,
                                                         input logic signed [DATA_W-1:0] data,
                                                         input logic [PRIO_W-1:0] prio);
        queue_result_t r;
        int pos;
        int i;
        r.status = STATUS_OK;
        r.data   = '0;
        r.prio   = '0;
        if (func == FUNC_ENQ)
        begin
            if (sorted_count >= QUEUE_DEPTH)
                r.status = STATUS_FULL;
            else
            begin
                pos = 0;
                while (pos < sorted_count && sorted_prio[pos] <= prio)
                    pos++;
                for (i = sorted_count; i > pos; i--)
                begin
                    sorted_value[i] = sorted_value[i-1];
                    sorted_prio[i]  = sorted_prio[i-1];
                end
                sorted_value[pos] = data;
                sorted_prio[pos]  = prio;
                sorted_count++;
            end
        end
        else
        begin
            if (sorted_count == 0)
            begin
                r.status = STATUS_EMPTY;
                r.data   = '1;
                r.prio   = '1;
            end
            else
            begin
                r.data = sorted_value[0];
                r.prio = {1'b0, sorted_prio[0]};
                for (i = 1; i < sorted_count; i++)
                begin
                    sorted_value[i-1] = sorted_value[i];
                    sorted_prio[i-1]  = sorted_prio[i];
                end
                sorted_count--;
            end
        end
        r.occupancy = sorted_count[OCC_W-1:0];
        return r;
    endfunction

    // predict on request transactions first, so even a same-edge response finds its entry
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                if (req_ch.func == FUNC_DEQ && sorted_count > 0)
                    pops_ok++;
                expected_results.push_back(sorted_queue_apply(req_ch.func, req_ch.in_data,
                                                              req_ch.in_prio));
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("response transaction with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        mismatches++;
                    end
                    if (rsp_ch.out_data !== want.data)
                    begin
                        $error("out_data: expected %0d, got %0d", want.data, rsp_ch.out_data);
                        mismatches++;
                    end
                    if (rsp_ch.out_prio !== want.prio)
                    begin
                        $error("out_prio: expected %0d, got %0d", want.prio, rsp_ch.out_prio);
                        mismatches++;
                    end
                    if (rsp_ch.occupancy !== want.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d", want.occupancy,
                               rsp_ch.occupancy);
                        mismatches++;
                    end
                    if (want.status == STATUS_FULL)
                        rejects_full++;
                    else if (want.status == STATUS_EMPTY)
                        rejects_empty++;
                end
            end
        end
    end

    // receiver: random stalls plus an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_item(input logic func, input logic signed [DATA_W-1:0] data,
                             input logic [PRIO_W-1:0] prio);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            req_ch.valid   <= 1'b0;
            req_ch.func    <= 1'($urandom_range(1));
            req_ch.in_data <= $urandom;
            req_ch.in_prio <= PRIO_W'($urandom_range(255));
        end
        @(negedge clk);
        req_ch.valid   <= 1'b1;
        req_ch.func    <= func;
        req_ch.in_data <= data;
        req_ch.in_prio <= prio;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_dequeue();
        send_item(FUNC_DEQ, $urandom, PRIO_W'($urandom_range(255)));
    endtask

    // fill with both priority extremes and two tie groups, then push once more than fits
    task automatic test_fill_to_full();
        int i;
        logic [PRIO_W-1:0] prio;
        logic signed [DATA_W-1:0] data;
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (i == 0)
            begin
                prio = 8'hFF;
                data = 32'sh7FFF_FFFF;
            end
            else if (i == 1)
            begin
                prio = 8'h00;
                data = 32'sh8000_0000;
            end
            else
            begin
                prio = (i % 2) ? 8'd7 : 8'd100;
                data = i;
            end
            send_item(FUNC_ENQ, data, prio);
        end
        send_item(FUNC_ENQ, -1, 8'h00);
    endtask

    // front first, then the priority-7 ties in arrival order
    task automatic test_ordered_drain();
        repeat (6)
            send_item(FUNC_DEQ, $urandom, PRIO_W'($urandom_range(255)));
    endtask

    // sweep between full and empty, mostly in biased runs, with some plain noise
    task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct);
        logic filling;
        logic func;
        logic [PRIO_W-1:0] prio;
        int n;
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        filling = 1'b1;
        for (n = 0; n < items; n++)
        begin
            if (sorted_count >= QUEUE_DEPTH && $urandom_range(3) == 0)
                filling = 1'b0;
            else if (sorted_count == 0 && $urandom_range(3) == 0)
                filling = 1'b1;
            else if ($urandom_range(29) == 0)
                filling = ~filling;
            if ($urandom_range(9) == 0)
                func = 1'($urandom_range(1));
            else
                func = ($urandom_range(99) < 75) ? (filling ? FUNC_ENQ : FUNC_DEQ)
                                                 : (filling ? FUNC_DEQ : FUNC_ENQ);
            case ($urandom_range(3))
                0: prio = PRIO_W'($urandom_range(3));
                1: prio = $urandom_range(1) ? 8'hFF : 8'h00;
                default: prio = PRIO_W'($urandom_range(255));
            endcase
            send_item(func, $urandom, prio);
        end
        wait_drained();
    endtask

    // stop the receiver while requests keep coming so the held output backs up the request channel
    task automatic test_backpressure();
        int n;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        for (n = 0; n < 40; n++)
            send_item((n < 30) ? FUNC_ENQ : FUNC_DEQ, $urandom,
                      PRIO_W'($urandom_range(255)));
        wait_drained();
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.func    = FUNC_ENQ;
        req_ch.in_data = '0;
        req_ch.in_prio = '0;
        rsp_ch.ready   = 1'b0;
        sorted_count   = 0;
        send_idle_pct  = 0;
        rsp_stall_pct  = 0;
        hold_left      = 0;
        idle_cycles    = 0;
        mismatches     = 0;
        results_checked = 0;
        pops_ok        = 0;
        rejects_full   = 0;
        rejects_empty  = 0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_dequeue();
        test_fill_to_full();
        test_ordered_drain();
        wait_drained();

        test_random_traffic(PHASE_ITEMS, 0, 0);
        test_random_traffic(PHASE_ITEMS, 87, 0);
        test_random_traffic(PHASE_ITEMS, 0, 87);
        test_random_traffic(PHASE_ITEMS, 38, 38);
        test_backpressure();

        repeat (4)
            @(posedge clk);
        $display("summary: %0d responses checked, %0d pops, %0d full rejects, %0d empty rejects",
                 results_checked, pops_ok, rejects_full, rejects_empty);
        $display("summary: idle and stall phases plus a %0d-cycle receiver hold-off",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
src/spq_pkg.sv
src/spq_if.sv
src/spq_datapath.sv
src/spq_ctrl.sv
src/stable_priority_queue_unit.sv
sim/stable_priority_queue_unit_tb.sv
